FILE: rtl/autocorrelation_engine_macros.svh
// Assertion macros used by the checker file of the autocorrelation engine.
`ifndef AUTOCORRELATION_ENGINE_MACROS_SVH
`define AUTOCORRELATION_ENGINE_MACROS_SVH

// Implication checked on every edge outside reset.
`define ACORR_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked on every edge outside reset.
`define ACORR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define ACORR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/acorr_pkg.sv
// ----------------------------------------------------------------------------
// acorr_pkg
// Types and fixed widths shared by the autocorrelation engine modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package acorr_pkg;

  localparam int SAMPLE_W  = 16;  // width of the sample port
  localparam int LAG_W     = 10;  // width of the lag port
  localparam int SUM_W     = 42;  // width of the returned sum
  localparam int STATUS_W  = 2;
  localparam int CMD_X_W   = 24;  // widest sample the engine supports
  localparam int CMD_IDX_W = 16;  // widest record index the engine supports

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_LAG  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_READ,
    CMD_DROP,
    CMD_BADLAG
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t              kind;
    logic [CMD_X_W-1:0]     x;
    logic [CMD_IDX_W-1:0]   idx;
  } acorr_cmd_t;

  typedef struct packed {
    logic [SUM_W-1:0]    lag_sum;
    logic [STATUS_W-1:0] status;
  } acorr_res_t;

endpackage

FILE: rtl/acorr_fifo.sv
// ----------------------------------------------------------------------------
// acorr_fifo
// Small register-based first-in first-out queue with push/full and pop/empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acorr_fifo #(
  parameter int W     = 8,
  parameter int LOG_D = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int D = 1 << LOG_D;

  logic [W-1:0]     mem_r [D];
  logic [LOG_D-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [LOG_D-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [LOG_D:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == (LOG_D + 1)'(D));
  assign empty   = (count_r == '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? LOG_D'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? LOG_D'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = (LOG_D + 1)'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = (LOG_D + 1)'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: rtl/acorr_front.sv
// ----------------------------------------------------------------------------
// acorr_front
// Accepts requests, keeps the record length and turns each request into a
// command for the back end: push, read, dropped push or out-of-range read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acorr_front #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  logic                                operation,
  input  logic signed [acorr_pkg::SAMPLE_W-1:0] sample,
  input  logic                                first,
  input  logic [acorr_pkg::LAG_W-1:0]         lag_index,
  output acorr_pkg::acorr_cmd_t               cmd
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int EXT_W  = (SAMPLE_BITS > acorr_pkg::SAMPLE_W) ? SAMPLE_BITS
                                                             : acorr_pkg::SAMPLE_W;
  localparam int LAGX_W = (CNT_W > acorr_pkg::LAG_W) ? CNT_W : acorr_pkg::LAG_W;

  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [CNT_W-1:0]              cnt_eff;
  logic [EXT_W-1:0]              raw;
  logic signed [SAMPLE_BITS-1:0] xs;

  // The port bits are taken as they stand; only the low SAMPLE_BITS carry sign.
  assign raw     = EXT_W'($unsigned(sample));
  assign xs      = raw[SAMPLE_BITS-1:0];
  assign cnt_eff = first ? '0 : count_r;

  always_comb begin
    count_nxt = count_r;
    cmd.x     = acorr_pkg::CMD_X_W'(xs);
    cmd.idx   = acorr_pkg::CMD_IDX_W'(lag_index);
    if (operation == acorr_pkg::OP_PUSH) begin
      cmd.idx = acorr_pkg::CMD_IDX_W'(cnt_eff);
      if (cnt_eff >= CNT_W'(DEPTH)) begin
        cmd.kind = acorr_pkg::CMD_DROP;
      end else begin
        cmd.kind = acorr_pkg::CMD_PUSH;
        if (accept) begin
          count_nxt = CNT_W'(cnt_eff + 1'b1);
        end
      end
    end else if (LAGX_W'(lag_index) < LAGX_W'(count_r)) begin
      cmd.kind = acorr_pkg::CMD_READ;
    end else begin
      cmd.kind = acorr_pkg::CMD_BADLAG;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule

FILE: rtl/acorr_back.sv
// ----------------------------------------------------------------------------
// acorr_back
// Carries out commands: a push stores the sample and sweeps the lag
// accumulators through a three-stage multiply-accumulate pipeline; a read
// fetches one accumulator and saturates it to the result width.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module acorr_back #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cmd_empty,
  input  acorr_pkg::acorr_cmd_t cmd,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output logic                  res_push,
  output acorr_pkg::acorr_res_t res
);

  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ACC_W = 2 * SAMPLE_BITS + $clog2(DEPTH);
  localparam int PROD_W = 2 * SAMPLE_BITS;
  localparam int SUM_W = acorr_pkg::SUM_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STORE,
    S_RUN,
    S_DRAIN,
    S_READ,
    S_RDATA,
    S_EMIT
  } state_t;

  state_t                        state_r, state_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r, x_nxt;
  logic [AW-1:0]                 t_r, t_nxt;
  logic [AW-1:0]                 k_r, k_nxt;
  acorr_pkg::acorr_res_t         res_r, res_nxt;

  logic                          v1_r, fresh1_r;
  logic [AW-1:0]                 k1_r;
  logic                          v2_r;
  logic [AW-1:0]                 k2_r;
  logic signed [PROD_W-1:0]      prod_r, prod_nxt;
  logic signed [ACC_W-1:0]       acc2_r, acc2_nxt;

  logic signed [SAMPLE_BITS-1:0] store_mem [DEPTH];
  logic signed [ACC_W-1:0]       acc_mem [DEPTH];
  logic signed [SAMPLE_BITS-1:0] store_q_r;
  logic signed [ACC_W-1:0]       acc_q_r;

  logic                          issue;
  logic [AW-1:0]                 store_ra, acc_ra;
  logic signed [ACC_W-1:0]       acc_wd;
  logic signed [SUM_W-1:0]       sat_sum;

  assign cmd_pop  = (state_r == S_IDLE) && !cmd_empty;
  assign res_push = (state_r == S_EMIT) && !res_full;
  assign res      = res_r;
  assign issue    = (state_r == S_RUN);

  // Product for lag k pairs the new sample with the one k places earlier.
  assign store_ra = AW'(t_r - k_r);
  assign acc_ra   = (state_r == S_READ) ? t_r : k_r;
  assign acc_wd   = acc2_r + ACC_W'(prod_r);
  assign prod_nxt = x_r * store_q_r;
  assign acc2_nxt = fresh1_r ? '0 : acc_q_r;

  generate
    if (ACC_W <= SUM_W) begin : g_widen
      assign sat_sum = SUM_W'(acc_q_r);
    end else begin : g_clip
      logic [ACC_W-SUM_W:0] hi;
      logic                 fits;
      assign hi      = acc_q_r[ACC_W-1:SUM_W-1];
      assign fits    = (hi == '0) || (hi == '1);
      assign sat_sum = fits ? acc_q_r[SUM_W-1:0]
                     : (acc_q_r[ACC_W-1] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                         : {1'b0, {(SUM_W - 1){1'b1}}});
    end
  endgenerate

  always_comb begin
    state_nxt = state_r;
    x_nxt     = x_r;
    t_nxt     = t_r;
    k_nxt     = k_r;
    res_nxt   = res_r;
    case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          x_nxt = cmd.x[SAMPLE_BITS-1:0];
          t_nxt = cmd.idx[AW-1:0];
          k_nxt = '0;
          case (cmd.kind)
            acorr_pkg::CMD_PUSH: state_nxt = S_STORE;
            acorr_pkg::CMD_READ: state_nxt = S_READ;
            acorr_pkg::CMD_DROP: begin
              res_nxt.lag_sum = '0;
              res_nxt.status  = acorr_pkg::ST_FULL;
              state_nxt       = S_EMIT;
            end
            default: begin
              res_nxt.lag_sum = '0;
              res_nxt.status  = acorr_pkg::ST_LAG;
              state_nxt       = S_EMIT;
            end
          endcase
        end
      end
      S_STORE: state_nxt = S_RUN;
      S_RUN: begin
        k_nxt = AW'(k_r + 1'b1);
        if (k_r == t_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!v1_r && !v2_r) begin
          res_nxt.lag_sum = '0;
          res_nxt.status  = acorr_pkg::ST_OK;
          state_nxt       = S_EMIT;
        end
      end
      S_READ: state_nxt = S_RDATA;
      S_RDATA: begin
        res_nxt.lag_sum = sat_sum;
        res_nxt.status  = acorr_pkg::ST_OK;
        state_nxt       = S_EMIT;
      end
      S_EMIT: begin
        if (!res_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      x_r      <= x_nxt;
      t_r      <= t_nxt;
      k_r      <= k_nxt;
      res_r    <= res_nxt;
      v1_r     <= issue;
      fresh1_r <= issue && (k_r == t_r);
      k1_r     <= k_r;
      v2_r     <= v1_r;
      k2_r     <= k1_r;
      prod_r   <= prod_nxt;
      acc2_r   <= acc2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_STORE) begin
      store_mem[t_r] <= x_r;
    end
    store_q_r <= store_mem[store_ra];
  end

  always_ff @(posedge clk) begin
    if (v2_r) begin
      acc_mem[k2_r] <= acc_wd;
    end
    acc_q_r <= acc_mem[acc_ra];
  end

endmodule

FILE: rtl/autocorrelation_engine.sv
// ----------------------------------------------------------------------------
// autocorrelation_engine
// Direct unnormalised autocorrelation over a stored record of samples.
// ----------------------------------------------------------------------------
// Requests enter on the push/full side: operation 0 adds a sample to the
// record (first = 1 restarts the record), operation 1 asks for the sum at
// lag_index. Every request yields exactly one result on the empty/pop side,
// in request order. A push returns sum 0 with status ok, or status full when
// the record already holds DEPTH samples; a read past the record returns 0
// with status lag.
// A push of record position t occupies the back end while the single
// multiply-accumulate pipeline visits one lag accumulator per cycle. A read
// passes through the read, read-data and emit states; a dropped push or
// out-of-range read goes straight to emit. A four-entry request queue
// lets requests arrive while the back end works, and a two-entry result
// queue holds finished results when the receiver stalls; full rises once the
// request queue fills. Reset empties both queues and clears the record
// length; the sample and accumulator memories are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module autocorrelation_engine #(
  parameter int DEPTH       = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  in_operation,
  input  logic signed [acorr_pkg::SAMPLE_W-1:0] in_sample,
  input  logic                                  in_first,
  input  logic [acorr_pkg::LAG_W-1:0]           in_lag_index,
  output logic                                  empty,
  input  logic                                  pop,
  output logic signed [acorr_pkg::SUM_W-1:0]    out_lag_sum,
  output logic [acorr_pkg::STATUS_W-1:0]        out_status
);

  localparam int CMD_W = $bits(acorr_pkg::acorr_cmd_t);
  localparam int RES_W = $bits(acorr_pkg::acorr_res_t);

  logic                  accept;
  acorr_pkg::acorr_cmd_t cmd_in, cmd_q;
  logic [CMD_W-1:0]      cmdq_rdata;
  logic                  cmdq_empty, cmd_pop;
  acorr_pkg::acorr_res_t res_in, res_q;
  logic [RES_W-1:0]      resq_rdata;
  logic                  res_full, res_push;

  assign accept = push && !full;

  acorr_front #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .operation (in_operation),
    .sample    (in_sample),
    .first     (in_first),
    .lag_index (in_lag_index),
    .cmd       (cmd_in)
  );

  acorr_fifo #(
    .W     (CMD_W),
    .LOG_D (2)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (cmd_in),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmdq_rdata),
    .empty (cmdq_empty)
  );

  assign cmd_q = acorr_pkg::acorr_cmd_t'(cmdq_rdata);

  acorr_back #(
    .DEPTH       (DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_empty (cmdq_empty),
    .cmd       (cmd_q),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  acorr_fifo #(
    .W     (RES_W),
    .LOG_D (1)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (resq_rdata),
    .empty (empty)
  );

  assign res_q       = acorr_pkg::acorr_res_t'(resq_rdata);
  assign out_lag_sum = res_q.lag_sum;
  assign out_status  = res_q.status;

endmodule

FILE: rtl/acorr_checker.sv
// ----------------------------------------------------------------------------
// acorr_checker
// Port-level checks on the autocorrelation engine, bound to its top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "autocorrelation_engine_macros.svh"

module acorr_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  full,
  input logic                                  empty,
  input logic                                  pop,
  input logic signed [acorr_pkg::SUM_W-1:0]    out_lag_sum,
  input logic [acorr_pkg::STATUS_W-1:0]        out_status
);

  logic status_known;

  assign status_known = (out_status == acorr_pkg::ST_OK) ||
                        (out_status == acorr_pkg::ST_LAG) ||
                        (out_status == acorr_pkg::ST_FULL);

  // Reset leaves no result waiting and room for a request.
  `ACORR_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, !rst_n, empty && !full, "reset did not empty the queues")

  // A result that is not taken stays as it is.
  `ACORR_ASSERT_NEXT(a_result_holds, clk, rst_n, !empty && !pop, !empty && $stable(out_lag_sum) && $stable(out_status), "waiting result changed")

  // Only the three defined status codes appear.
  `ACORR_ASSERT(a_status_code, clk, rst_n, !empty, status_known, "undefined status code")

  // A failed request never carries a sum.
  `ACORR_ASSERT(a_error_zero, clk, rst_n, !empty && (out_status != acorr_pkg::ST_OK), out_lag_sum == '0, "error result with non-zero sum")

endmodule

bind autocorrelation_engine acorr_checker u_checker (.*);
